// ----- design/conv2d_zero_padded_stream_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef CONV2D_ZERO_PADDED_STREAM_UNIT_MACROS_SVH
`define CONV2D_ZERO_PADDED_STREAM_UNIT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define C2DZ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define C2DZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/c2dz_pkg.sv -----
// Shared types and constants of the 2D convolution stream unit.
package c2dz_pkg;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [2:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [2:0] REG_FRAC_BITS    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_RED,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic acc_clr;
        logic issue;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- design/c2dz_cell.sv -----
// One kernel-row cell: line bank, coefficient copy, MAC and sum hand-off.
module c2dz_cell
    import c2dz_pkg::*;
#(
    parameter int KERNEL_MAX = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CELL_IDX   = 0,
    parameter int SW         = 38,
    parameter int CW         = 10,
    parameter int HW         = 11,
    parameter int KB         = 3,
    parameter int KW         = 3,
    parameter int CA         = 6,
    parameter int TW         = 14
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic                 cwe,
    input  logic [CA-1:0]        cwaddr,
    input  logic signed [15:0]   cdata,
    input  logic                 lwe,
    input  logic [KB-1:0]        lbank,
    input  logic [CW-1:0]        lcol,
    input  logic signed [15:0]   ldata,
    input  logic [CW-1:0]        raddr,
    input  logic                 col_ok,
    input  logic [KB-1:0]        b_idx,
    input  logic [KB-1:0]        top_mod,
    input  logic [TW-1:0]        top,
    input  logic [KW-1:0]        kr,
    input  logic [HW-1:0]        h,
    input  logic signed [SW-1:0] acc_in,
    output logic signed [SW-1:0] acc_out
);

    localparam int NC = KERNEL_MAX * KERNEL_MAX;

    logic signed [15:0] line_mem [MAX_WIDTH];
    logic signed [15:0] coef_mem [NC];
    logic [NC-1:0]      coef_vld_reg;

    logic signed [15:0] pix_reg;
    logic signed [15:0] cf_reg;
    logic               en1_reg;
    logic signed [31:0] prod_reg;
    logic               en2_reg;
    logic signed [SW-1:0] acc_reg;

    logic [KB-1:0] a_idx;
    logic          row_ok;
    logic [CA-1:0] craddr;
    logic [31:0]   ca_wide;

    // kernel row this bank serves for the current output row
    always_comb
    begin
        if (32'(top_mod) >= CELL_IDX)
            a_idx = KB'(32'(top_mod) - CELL_IDX);
        else
            a_idx = KB'(32'(top_mod) + KERNEL_MAX - CELL_IDX);
        row_ok  = (32'(a_idx) < 32'(kr)) && (32'(top) >= 32'(a_idx)) &&
                  ((32'(top) - 32'(a_idx)) < 32'(h));
        ca_wide = 32'(a_idx) * KERNEL_MAX + 32'(b_idx);
        craddr  = ca_wide[CA-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (lwe && (32'(lbank) == CELL_IDX))
            line_mem[lcol] <= ldata;
        pix_reg <= line_mem[raddr];
        if (cwe)
            coef_mem[cwaddr] <= cdata;
        cf_reg <= coef_vld_reg[craddr] ? coef_mem[craddr] : 16'sd0;
        prod_reg <= pix_reg * cf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            en1_reg      <= 1'b0;
            en2_reg      <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            if (cwe)
                coef_vld_reg[cwaddr] <= 1'b1;
            en1_reg <= ctrl.issue && row_ok && col_ok;
            en2_reg <= en1_reg;
            if (ctrl.acc_clr)
                acc_reg <= '0;
            else if (ctrl.shift)
                acc_reg <= acc_in;
            else if (en2_reg)
                acc_reg <= acc_reg + SW'(prod_reg);
        end
    end

    assign acc_out = acc_reg;

endmodule

// ----- design/conv2d_zero_padded_stream_unit.sv -----
// Top level of the zero-padded 2D convolution stream unit.
// Use:
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): geometry and scaling;
//    writing width, height or kernel size restarts the frame. Write only when idle.
//  - input channel (in_valid/in_ready): mode 0 loads a coefficient, mode 1 is a
//    raster pixel, mode 2 a zero flush pixel past the frame end; mode 3 is dropped.
//  - output channel (out_valid/out_ready): one convolved pixel with its row,
//    column and frame_last flag, at most one per input beat.
// Steps: a beat that yields no result only steps the input position. A beat that
// yields a result is accepted, then the column steps run through the cell row (line
// read, multiply, accumulate), the partial sums are handed down the cell row, and
// the sum is scaled and loaded into the output register, which drives out_valid.
// Each cell owns one line bank (one read port), so columns go one per cycle.
// The result sits in an output register; the next beat is taken while it waits.
// If the receiver stalls, the block holds the next result in the scale state.
// Reset: coefficients read as zero, positions go to zero, geometry returns
// to 1024x1024, 3x3 kernel, no fraction bits. Line banks need no clearing.
module conv2d_zero_padded_stream_unit
    import c2dz_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int KERNEL_MAX = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [2:0]         coef_row,
    input  logic [2:0]         coef_col,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_pixel,
    output logic [9:0]         out_row,
    output logic [9:0]         out_col,
    output logic               frame_last
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2;
    localparam int KB  = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int KW  = $clog2(KERNEL_MAX + 1);
    localparam int CA  = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX * KERNEL_MAX) : 1;
    localparam int SW  = 32 + $clog2(KERNEL_MAX * KERNEL_MAX + 1);
    localparam int TW  = RW + KB + 1;
    localparam int SCW = CW + KB + 3;
    localparam int NW  = $clog2(KERNEL_MAX + 2);

    state_t state_reg, state_next;
    cell_ctrl_t ctrl;

    logic [10:0] fw_reg, fh_reg;
    logic [2:0]  kr_cfg_reg, kc_cfg_reg;
    logic [3:0]  frac_reg;

    logic [PW-1:0] in_pos_reg, out_pos_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [KB-1:0] in_bank_reg, out_rmod_reg;
    logic [RW-1:0] out_row_reg;
    logic [NW-1:0] cnt_reg;
    logic signed [SW-1:0] sum_reg;

    logic signed [15:0] opix_reg;
    logic [9:0]         orow_reg, ocol_reg;
    logic               olast_reg, ovalid_reg;

    // clamped geometry
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [KW-1:0] kr, kc, offy, offx;
    logic [PW-1:0] total, delay;
    always_comb
    begin
        w  = (fw_reg == 11'd0) ? WW'(1) :
             (32'(fw_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw_reg);
        h  = (fh_reg == 11'd0) ? HW'(1) :
             (32'(fh_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh_reg);
        kr = (kr_cfg_reg == 3'd0) ? KW'(1) :
             (32'(kr_cfg_reg) > KERNEL_MAX) ? KW'(KERNEL_MAX) : KW'(kr_cfg_reg);
        kc = (kc_cfg_reg == 3'd0) ? KW'(1) :
             (32'(kc_cfg_reg) > KERNEL_MAX) ? KW'(KERNEL_MAX) : KW'(kc_cfg_reg);
        offy  = (kr - KW'(1)) >> 1;
        offx  = (kc - KW'(1)) >> 1;
        total = PW'(w) * PW'(h);
        delay = PW'(offy) * PW'(w) + PW'(offx);
    end

    logic in_acc, out_acc, cfg_acc, is_sample, out_go, out_free, last_pix;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = ovalid_reg && out_ready;
    assign out_free  = !ovalid_reg || out_ready;
    assign is_sample = (mode == MODE_PIXEL) || (mode == MODE_FLUSH);
    assign out_go    = (in_pos_reg >= delay) && (out_pos_reg < total);
    assign last_pix  = (out_pos_reg == total - PW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc && is_sample && out_go)
                    state_next = ST_MAC;
            ST_MAC:
                if (32'(cnt_reg) == 32'(kc) + 1)
                    state_next = ST_RED;
            ST_RED:
                if (32'(cnt_reg) == KERNEL_MAX - 1)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready     = 1'b0;
        ctrl.acc_clr = 1'b0;
        ctrl.issue   = 1'b0;
        ctrl.shift   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            ST_MAC:
                ctrl.issue = (32'(cnt_reg) < 32'(kc));
            ST_RED:
                ctrl.shift = 1'b1;
            ST_EMIT:
                ;
            default:
                ;
        endcase
    end

    // window geometry for the current output pixel
    logic [TW-1:0]  top;
    logic [KB-1:0]  top_mod;
    logic [31:0]    tm_wide;
    logic signed [SCW-1:0] col_s;
    logic           col_ok;
    logic [CW-1:0]  raddr;
    logic [KB-1:0]  b_idx;
    always_comb
    begin
        top     = TW'(out_row_reg) + TW'(offy);
        tm_wide = 32'(out_rmod_reg) + 32'(offy);
        if (tm_wide >= KERNEL_MAX)
            tm_wide = tm_wide - KERNEL_MAX;
        top_mod = tm_wide[KB-1:0];
        b_idx   = cnt_reg[KB-1:0];
        col_s   = $signed(SCW'(out_col_reg)) + $signed(SCW'(offx)) -
                  $signed(SCW'(cnt_reg));
        col_ok  = (col_s >= 0) && (col_s < $signed(SCW'(w)));
        raddr   = col_s[CW-1:0];
    end

    // coefficient and line writes
    logic          cwe, lwe;
    logic [CA-1:0] cwaddr;
    logic [31:0]   cw_wide;
    logic signed [15:0] ldata;
    always_comb
    begin
        cw_wide = 32'(coef_row) * KERNEL_MAX + 32'(coef_col);
        cwaddr  = cw_wide[CA-1:0];
        cwe     = in_acc && (mode == MODE_COEF) &&
                  (32'(coef_row) < KERNEL_MAX) && (32'(coef_col) < KERNEL_MAX);
        lwe     = in_acc && is_sample && (in_pos_reg < total);
        ldata   = (mode == MODE_PIXEL) ? value : 16'sd0;
    end

    // cell row; partial sums move toward cell 0
    logic signed [SW-1:0] acc_chain [KERNEL_MAX + 1];
    assign acc_chain[KERNEL_MAX] = '0;

    for (genvar k = 0; k < KERNEL_MAX; k++)
    begin : g_cell
        c2dz_cell #(
            .KERNEL_MAX (KERNEL_MAX),
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_HEIGHT (MAX_HEIGHT),
            .CELL_IDX   (k),
            .SW         (SW),
            .CW         (CW),
            .HW         (HW),
            .KB         (KB),
            .KW         (KW),
            .CA         (CA),
            .TW         (TW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .cwe     (cwe),
            .cwaddr  (cwaddr),
            .cdata   (value),
            .lwe     (lwe),
            .lbank   (in_bank_reg),
            .lcol    (in_col_reg),
            .ldata   (ldata),
            .raddr   (raddr),
            .col_ok  (col_ok),
            .b_idx   (b_idx),
            .top_mod (top_mod),
            .top     (top),
            .kr      (kr),
            .h       (h),
            .acc_in  (acc_chain[k + 1]),
            .acc_out (acc_chain[k])
        );
    end

    // scale and saturate
    logic signed [SW-1:0] y;
    logic signed [15:0]   y_sat;
    always_comb
    begin
        y = sum_reg >>> frac_reg;
        if (y > $signed(SW'(32767)))
            y_sat = 16'sh7FFF;
        else if (y < -$signed(SW'(32768)))
            y_sat = -16'sh8000;
        else
            y_sat = y[15:0];
    end

    // position advance
    logic [CW-1:0] in_col_next, out_col_next;
    logic [KB-1:0] in_bank_next, out_rmod_next;
    logic [RW-1:0] out_row_next;
    logic          in_wrap, out_wrap;
    always_comb
    begin
        in_wrap       = (WW'(in_col_reg) + WW'(1) == w);
        out_wrap      = (WW'(out_col_reg) + WW'(1) == w);
        in_col_next   = in_wrap ? '0 : in_col_reg + CW'(1);
        in_bank_next  = in_bank_reg;
        if (in_wrap)
            in_bank_next = (32'(in_bank_reg) == KERNEL_MAX - 1) ? '0 :
                           in_bank_reg + KB'(1);
        out_col_next  = out_wrap ? '0 : out_col_reg + CW'(1);
        out_row_next  = out_wrap ? out_row_reg + RW'(1) : out_row_reg;
        out_rmod_next = out_rmod_reg;
        if (out_wrap)
            out_rmod_next = (32'(out_rmod_reg) == KERNEL_MAX - 1) ? '0 :
                            out_rmod_reg + KB'(1);
    end

    logic [31:0] orow_wide, ocol_wide;
    assign orow_wide = 32'(out_row_reg);
    assign ocol_wide = 32'(out_col_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            sum_reg <= '0;
        else if (state_reg == ST_RED)
            sum_reg <= sum_reg + acc_chain[0];
        if (state_reg == ST_EMIT && out_free)
        begin
            opix_reg  <= y_sat;
            orow_reg  <= orow_wide[9:0];
            ocol_reg  <= ocol_wide[9:0];
            olast_reg <= last_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fw_reg       <= 11'd1024;
            fh_reg       <= 11'd1024;
            kr_cfg_reg   <= 3'd3;
            kc_cfg_reg   <= 3'd3;
            frac_reg     <= 4'd0;
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            in_col_reg   <= '0;
            in_bank_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_rmod_reg <= '0;
            cnt_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? '0 : cnt_reg + NW'(1);

            if (out_acc && !(state_reg == ST_EMIT && out_free))
                ovalid_reg <= 1'b0;

            if (cfg_acc)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg     <= cfg_data;
                    REG_FRAME_HEIGHT: fh_reg     <= cfg_data;
                    REG_KERNEL_ROWS:  kr_cfg_reg <= cfg_data[2:0];
                    REG_KERNEL_COLS:  kc_cfg_reg <= cfg_data[2:0];
                    REG_FRAC_BITS:    frac_reg   <= cfg_data[3:0];
                    default:          ;
                endcase
                if (cfg_index <= REG_KERNEL_COLS)
                begin
                    in_pos_reg   <= '0;
                    out_pos_reg  <= '0;
                    in_col_reg   <= '0;
                    in_bank_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_rmod_reg <= '0;
                end
            end

            // sample beat with no result: just step the input side
            if (in_acc && is_sample && !out_go)
            begin
                in_pos_reg  <= in_pos_reg + PW'(1);
                in_col_reg  <= in_col_next;
                in_bank_reg <= in_bank_next;
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                ovalid_reg <= 1'b1;
                if (last_pix)
                begin
                    in_pos_reg   <= '0;
                    out_pos_reg  <= '0;
                    in_col_reg   <= '0;
                    in_bank_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_rmod_reg <= '0;
                end
                else
                begin
                    in_pos_reg   <= in_pos_reg + PW'(1);
                    out_pos_reg  <= out_pos_reg + PW'(1);
                    in_col_reg   <= in_col_next;
                    in_bank_reg  <= in_bank_next;
                    out_col_reg  <= out_col_next;
                    out_row_reg  <= out_row_next;
                    out_rmod_reg <= out_rmod_next;
                end
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_pixel  = opix_reg;
    assign out_row    = orow_reg;
    assign out_col    = ocol_reg;
    assign frame_last = olast_reg;

endmodule

// ----- design/c2dz_checker.sv -----
// Port-level checker for the convolution stream unit, with its bind.
`include "conv2d_zero_padded_stream_unit_macros.svh"
module c2dz_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a stalled result beat stays offered
    `C2DZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // no result can appear the cycle right after an input beat
    `C2DZ_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))
    // a new result is loaded only from the scale step, where input is closed
    `C2DZ_ASSERT_IMPL(a_rise_after_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind conv2d_zero_padded_stream_unit c2dz_checker u_c2dz_checker (.*);
